// ===== src/bps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned PatternDepth = 16;
  localparam int unsigned TimeWidthDef = 16;
  localparam int unsigned IdxWidth     = $clog2(PatternDepth);
  localparam int unsigned MsWidth      = 16;
  localparam int unsigned CountWidth   = 8;
  localparam int unsigned LenWidth     = 5;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgWidth     = 16;

  localparam logic [MsWidth-1:0] BeepMsReset = 16'd100;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_BEEP    = 2'd2,
    MODE_PATTERN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_TICK          = 3'd0,
    ACT_START_ON      = 3'd1,
    ACT_START_BEEP    = 3'd2,
    ACT_START_PATTERN = 3'd3,
    ACT_WRITE_ENTRY   = 3'd4,
    ACT_STOP          = 3'd5
  } action_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SINGLE_ON_MS   = 3'd0,
    CFG_BEEP_ON_MS     = 3'd1,
    CFG_BEEP_OFF_MS    = 3'd2,
    CFG_BEEP_TOTAL     = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } cfg_idx_e;

  // result item, buzzer_level in the lowest bit
  typedef struct packed {
    mode_e mode;
    logic  level_changed;
    logic  buzzer_level;
  } result_t;

endpackage

// ===== src/buzzer_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Buzzer drive sequencer with off, one-shot, beeping and stored pattern modes,
// stepped by tick and command items, one result item per input item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tuser action, tdata index and time
//  m_axis    out  m_axis_tvalid/tready      tdata level, changed, mode
//  cfg       in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  one item per cycle while the input is not stalled: the whole state update is
//  one pass of logic from the accepted item into the state and result registers
//  a two-entry output buffer (result register plus skid) lets an item be
//  taken while one result waits; input stalls only when both are full
//  reset clears control state and registers; the pattern table is not reset
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer
  import bps_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TimeWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [23:0]            s_axis_tdata,  // entry_index[3:0], entry_time[19:4]
  input  logic [2:0]             s_axis_tuser,  // action[2:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata   // buzzer_level[0], level_changed[1], mode[3:2]
);

  localparam int unsigned CmpWidth = (TIME_WIDTH > MsWidth) ? TIME_WIDTH : MsWidth;

  // configuration registers
  logic [MsWidth-1:0]    single_on_q, beep_on_q, beep_off_q;
  logic [CountWidth-1:0] beep_total_q;
  logic [LenWidth-1:0]   pat_len_q;

  // sequencer state
  mode_e                 mode_q, mode_d;
  logic                  level_q, level_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [CountWidth-1:0] beeps_q, beeps_d;
  logic [IdxWidth-1:0]   idx_q, idx_d;
  logic [MsWidth-1:0]    table_q [PatternDepth];

  // output buffer
  logic    o_valid_q, o_valid_d, k_valid_q, k_valid_d;
  result_t o_data_q, o_data_d, k_data_q, k_data_d;

  logic                  push, pop, changed, table_we;
  action_e               action;
  logic [IdxWidth-1:0]   entry_idx;
  logic [MsWidth-1:0]    entry_time;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [MsWidth-1:0]    limit;
  logic [CmpWidth-1:0]   el_ext, lim_ext;
  logic [CountWidth-1:0] beeps_inc;
  logic [LenWidth-1:0]   len_eff, idx_plus;
  result_t               res;

  assign action     = action_e'(s_axis_tuser);
  assign entry_idx  = s_axis_tdata[IdxWidth-1:0];
  assign entry_time = s_axis_tdata[IdxWidth +: MsWidth];

  assign s_axis_tready = !k_valid_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = o_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_on_q  <= '0;
      beep_on_q    <= BeepMsReset;
      beep_off_q   <= BeepMsReset;
      beep_total_q <= '0;
      pat_len_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SINGLE_ON_MS:   single_on_q  <= cfg_data_i;
        CFG_BEEP_ON_MS:     beep_on_q    <= cfg_data_i;
        CFG_BEEP_OFF_MS:    beep_off_q   <= cfg_data_i;
        CFG_BEEP_TOTAL:     beep_total_q <= cfg_data_i[CountWidth-1:0];
        CFG_PATTERN_LENGTH: pat_len_q    <= cfg_data_i[LenWidth-1:0];
        default: ;
      endcase
    end
  end

  // shared helpers of the tick step
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + TIME_WIDTH'(1) : elapsed_q;
  assign beeps_inc   = (beeps_q != '1) ? beeps_q + CountWidth'(1) : beeps_q;
  assign len_eff     = (pat_len_q > LenWidth'(PatternDepth)) ? LenWidth'(PatternDepth)
                                                              : pat_len_q;
  assign idx_plus    = LenWidth'(idx_q) + LenWidth'(1);

  always_comb begin
    case (mode_q)
      MODE_ON:      limit = single_on_q;
      MODE_BEEP:    limit = level_q ? beep_on_q : beep_off_q;
      MODE_PATTERN: limit = table_q[idx_q];
      default:      limit = '0;
    endcase
  end

  assign el_ext  = CmpWidth'(elapsed_inc);
  assign lim_ext = CmpWidth'(limit);

  always_comb begin
    mode_d    = mode_q;
    level_d   = level_q;
    elapsed_d = elapsed_q;
    beeps_d   = beeps_q;
    idx_d     = idx_q;
    changed   = 1'b0;
    table_we  = 1'b0;
    if (push) begin
      case (action)
        ACT_TICK: begin
          elapsed_d = elapsed_inc;
          if (mode_q != MODE_OFF && el_ext >= lim_ext) begin
            changed = 1'b1;
            case (mode_q)
              MODE_ON: begin
                mode_d  = MODE_OFF;
                level_d = 1'b0;
              end
              MODE_BEEP: begin
                level_d   = !level_q;
                elapsed_d = '0;
                if (level_q) begin
                  if (beeps_inc >= beep_total_q) begin
                    mode_d  = MODE_OFF;
                    beeps_d = '0;
                  end else begin
                    beeps_d = beeps_inc;
                  end
                end
              end
              MODE_PATTERN: begin
                level_d   = !level_q;
                elapsed_d = '0;
                if (len_eff == '0) begin
                  idx_d   = '0;
                  mode_d  = MODE_OFF;
                  level_d = 1'b0;
                end else begin
                  idx_d = (idx_plus >= len_eff) ? '0 : idx_plus[IdxWidth-1:0];
                  if (idx_plus >= len_eff && level_q) begin
                    mode_d  = MODE_OFF;
                    level_d = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ACT_START_ON: begin
          mode_d    = MODE_ON;
          level_d   = 1'b1;
          elapsed_d = '0;
          changed   = 1'b1;
        end
        ACT_START_BEEP: begin
          beeps_d   = '0;
          mode_d    = MODE_BEEP;
          level_d   = 1'b0;
          elapsed_d = '0;
          changed   = 1'b1;
        end
        ACT_START_PATTERN: begin
          idx_d     = '0;
          mode_d    = MODE_PATTERN;
          level_d   = 1'b0;
          elapsed_d = '0;
          changed   = 1'b1;
        end
        ACT_WRITE_ENTRY: table_we = 1'b1;
        ACT_STOP: begin
          mode_d  = MODE_OFF;
          level_d = 1'b0;
          changed = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 1'b0;
      elapsed_q <= '0;
      beeps_q   <= '0;
      idx_q     <= '0;
    end else begin
      level_q   <= level_d;
      elapsed_q <= elapsed_d;
      beeps_q   <= beeps_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (table_we) begin
      table_q[entry_idx] <= entry_time;
    end
  end

  // result of the accepted item, taken after the update
  assign res.mode          = mode_d;
  assign res.level_changed = changed;
  assign res.buzzer_level  = level_d;

  always_comb begin
    o_valid_d = o_valid_q;
    o_data_d  = o_data_q;
    k_valid_d = k_valid_q;
    k_data_d  = k_data_q;
    if (!o_valid_q || pop) begin
      o_valid_d = k_valid_q || push;
      o_data_d  = k_valid_q ? k_data_q : res;
      k_valid_d = 1'b0;
    end else if (push) begin
      k_valid_d = 1'b1;
      k_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      k_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
      k_valid_q <= k_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_data_q <= o_data_d;
    k_data_q <= k_data_d;
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {4'b0000, o_data_q};

`ifndef SYNTHESIS
  // skid entry is only in use behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_valid_q |-> o_valid_q)
    else $error("skid entry valid without result register valid");

  // the block never rests off with the buzzer sounding
  a_off_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OFF) |-> !level_q)
    else $error("level high in off mode");

  // one-shot mode never lowers the level while it lasts, so the level stays high
  a_on_is_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ON) |-> level_q)
    else $error("level low in one-shot mode");

  // a beep start clears the count and begins in the low phase
  a_beep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && action == ACT_START_BEEP) |=>
      (mode_q == MODE_BEEP && beeps_q == '0 && !level_q && elapsed_q == '0))
    else $error("beep start did not set up the beep state");
`endif

endmodule

// ===== verif/buzzer_pattern_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_test
// Drives tick and command items into the sequencer under changing register
// settings and idle patterns, predicts level, changed flag and mode for each
// item and compares every result item in order.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer_test;
  import bps_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  class buzzer_tracker;
    logic [MsWidth-1:0]    single_on_ms;
    logic [MsWidth-1:0]    beep_on_ms;
    logic [MsWidth-1:0]    beep_off_ms;
    logic [CountWidth-1:0] beep_total;
    logic [LenWidth-1:0]   pattern_len;
    mode_e                 mode;
    logic                  level;
    logic [MsWidth-1:0]    elapsed;
    logic [CountWidth-1:0] beeps_done;
    logic [IdxWidth-1:0]   phase_idx;
    logic [MsWidth-1:0]    phase_time [PatternDepth];
    result_t               expected_levels [$];
    int                    errors;
    int                    results_seen;

    function new();
      single_on_ms = '0;
      beep_on_ms   = BeepMsReset;
      beep_off_ms  = BeepMsReset;
      beep_total   = '0;
      pattern_len  = '0;
      mode         = MODE_OFF;
      level        = 1'b0;
      elapsed      = '0;
      beeps_done   = '0;
      phase_idx    = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgWidth-1:0] value);
      case (idx)
        CFG_SINGLE_ON_MS:   single_on_ms = value;
        CFG_BEEP_ON_MS:     beep_on_ms = value;
        CFG_BEEP_OFF_MS:    beep_off_ms = value;
        CFG_BEEP_TOTAL:     beep_total = value[CountWidth-1:0];
        CFG_PATTERN_LENGTH: pattern_len = value[LenWidth-1:0];
        default: ;
      endcase
    endfunction

    function int levels_owed();
      return expected_levels.size();
    endfunction

    function void note_item(logic [2:0] act, logic [IdxWidth-1:0] slot,
                            logic [MsWidth-1:0] ms);
      logic               changed;
      logic [MsWidth-1:0] limit;
      logic [LenWidth-1:0] len;
      result_t            r;
      changed = 1'b0;
      case (act)
        ACT_TICK: begin
          if (elapsed != '1) elapsed++;
          case (mode)
            MODE_ON: begin
              if (elapsed >= single_on_ms) begin
                mode = MODE_OFF;
                level = 1'b0;
                changed = 1'b1;
              end
            end
            MODE_BEEP: begin
              limit = level ? beep_on_ms : beep_off_ms;
              if (elapsed >= limit) begin
                level = ~level;
                elapsed = '0;
                changed = 1'b1;
                if (!level) begin
                  if (beeps_done != '1) beeps_done++;
                  if (beeps_done >= beep_total) begin
                    mode = MODE_OFF;
                    beeps_done = '0;
                  end
                end
              end
            end
            MODE_PATTERN: begin
              if (elapsed >= phase_time[phase_idx]) begin
                level = ~level;
                elapsed = '0;
                changed = 1'b1;
                len = (pattern_len > PatternDepth) ? LenWidth'(PatternDepth) : pattern_len;
                if (len == 0) begin
                  // empty pattern stops at the first toggle
                  phase_idx = '0;
                  mode = MODE_OFF;
                  level = 1'b0;
                end else begin
                  if (phase_idx + 1 >= len) phase_idx = '0;
                  else phase_idx++;
                  if (phase_idx == 0 && !level) begin
                    mode = MODE_OFF;
                    level = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        ACT_START_ON: begin
          mode = MODE_ON;
          level = 1'b1;
          elapsed = '0;
          changed = 1'b1;
        end
        ACT_START_BEEP: begin
          beeps_done = '0;
          mode = MODE_BEEP;
          level = 1'b0;
          elapsed = '0;
          changed = 1'b1;
        end
        ACT_START_PATTERN: begin
          phase_idx = '0;
          mode = MODE_PATTERN;
          level = 1'b0;
          elapsed = '0;
          changed = 1'b1;
        end
        ACT_WRITE_ENTRY: phase_time[slot] = ms;
        ACT_STOP: begin
          mode = MODE_OFF;
          level = 1'b0;
          changed = 1'b1;
        end
        default: ;
      endcase
      r.mode = mode;
      r.level_changed = changed;
      r.buzzer_level = level;
      expected_levels.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[3:0]);
      results_seen++;
      if (expected_levels.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_levels.pop_front();
        if (got.buzzer_level !== want.buzzer_level)
          report($sformatf("result %0d buzzer_level %b, want %b", results_seen,
                           got.buzzer_level, want.buzzer_level));
        if (got.level_changed !== want.level_changed)
          report($sformatf("result %0d level_changed %b, want %b", results_seen,
                           got.level_changed, want.level_changed));
        if (got.mode !== want.mode)
          report($sformatf("result %0d mode %0d, want %0d", results_seen,
                           got.mode, want.mode));
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgWidth-1:0]    cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata = '0;  // entry_index[3:0], entry_time[19:4]
  logic [2:0]             s_axis_tuser = '0;  // action[2:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;       // buzzer_level[0], level_changed[1], mode[3:2]

  buzzer_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  buzzer_pattern_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("buzzer_pattern_sequencer test failed");
      $finish;
    end
  end

  function automatic logic [MsWidth-1:0] pick_time();
    if ($urandom_range(9) == 0) return MsWidth'($urandom);
    return MsWidth'($urandom_range(0, 12));
  endfunction

  // entered and left at a falling edge
  task automatic send_item(logic [2:0] act, logic [IdxWidth-1:0] slot,
                           logic [MsWidth-1:0] ms);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'b0, ms, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(act, slot, ms);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (tracker.levels_owed() != 0);
  endtask

  task automatic write_config(logic [CfgWidth-1:0] vals [5]);
    wait_drained();
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxWidth'(i);
      cfg_data_i <= vals[i];
      tracker.set_reg(cfg_idx_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CfgWidth-1:0] vals [5];
    int seg_end;
    int r;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: fill every slot, then start each mode and tick it, send both unused action codes and a stop
    for (int i = 0; i < PatternDepth; i++)
      send_item(ACT_WRITE_ENTRY, IdxWidth'(i),
                (i == 0) ? 16'h0000 : (i == PatternDepth - 1) ? 16'hffff : 16'(i % 3 + 1));
    send_item(ACT_START_ON, '0, '0);
    send_item(ACT_TICK, '1, '1);
    send_item(ACT_START_BEEP, '0, '0);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_START_PATTERN, '0, '0);
    send_item(ACT_TICK, '0, '0);
    send_item(3'd6, '0, '0);
    send_item(3'd7, '1, '1);
    send_item(ACT_STOP, '0, '0);

    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        1: vals = '{16'hffff, 16'hffff, 16'd0, 16'd255, 16'd16};
        5: vals = '{16'd3, 16'd0, 16'd0, 16'd255, 16'd31};
        default: begin
          vals[0] = 16'($urandom_range(0, 30));
          vals[1] = 16'($urandom_range(0, 10));
          vals[2] = 16'($urandom_range(0, 10));
          vals[3] = 16'($urandom_range(0, 8));
          vals[4] = 16'($urandom_range(0, 31));
        end
      endcase
      write_config(vals);
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct = 29;
        end
      endcase
      seg_end = items_sent + 112;
      while (items_sent < seg_end) begin
        r = $urandom_range(99);
        if (r < 72) begin
          send_item(3'($urandom_range(ACT_START_ON, ACT_START_PATTERN)),
                    IdxWidth'($urandom), MsWidth'($urandom));
          repeat ($urandom_range(1, 40)) begin
            if ($urandom_range(99) < 6)
              send_item(3'($urandom_range(0, 7)), IdxWidth'($urandom), pick_time());
            else
              send_item(ACT_TICK, IdxWidth'($urandom), MsWidth'($urandom));
          end
        end else if (r < 86) begin
          repeat ($urandom_range(1, 4))
            send_item(ACT_WRITE_ENTRY, IdxWidth'($urandom), pick_time());
        end else if (r < 96) begin
          send_item(($urandom_range(1) == 0) ? 3'(ACT_STOP) : 3'($urandom_range(6, 7)),
                    IdxWidth'($urandom), MsWidth'($urandom));
        end else begin
          wait_drained();
        end
      end
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (tracker.levels_owed() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.levels_owed()));
    if (tracker.errors == 0) begin
      $display("buzzer_pattern_sequencer test passed");
    end else begin
      $display("buzzer_pattern_sequencer test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bps_pkg.sv
src/buzzer_pattern_sequencer.sv
verif/buzzer_pattern_sequencer_test.sv
